>>> src/bws_pkg.sv
package bws_pkg;

    localparam int MAX_PAIRS  = 16;
    localparam int KEY_LEN    = 8;
    localparam int NUM_WORDS  = 2 * MAX_PAIRS;
    localparam int STORE_DEPTH = NUM_WORDS * KEY_LEN;
    localparam int WORD_W     = $clog2(NUM_WORDS);
    localparam int POS_W      = $clog2(KEY_LEN);
    localparam int LEN_W      = 4;
    localparam int LA_DEPTH   = KEY_LEN + 1;
    localparam int FILL_W     = 4;
    localparam int WCNT_W     = WORD_W + 1;
    localparam int PCNT_W     = 5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    typedef struct packed {
        logic load_accept;   // load word taken this cycle
        logic text_accept;   // text word taken this cycle
        logic push;          // emit one byte into the pending slot
        logic push_ram;      // pushed byte comes from the keyword store
        logic flush;         // move pending byte out, end of step
        logic drop_one;
        logic drop_word;
        logic set_pass;
        logic clr_pass;
        logic w_clr;
        logic w_inc;
        logic j_clr;
        logic j_inc;
        logic lat_len;
        logic lat_olen;
        logic rd_other;      // length read targets the partner word
        logic rd_emit;       // char read targets the partner word
    } t_dp_cmd;

    typedef struct packed {
        logic decide_req;
        logic pass;
        logic w_done;
        logic len_bad;
        logic char_eq;
        logic j_last;
        logic olen_zero;
        logic e_last;
        logic out_free;
        logic pend_valid;
    } t_dp_stat;

endpackage

>>> src/bidirectional_word_substitution_unit.sv
// channel  | direction | contents
// s_axis   | in        | tuser: cmd; tdata: pair_index, side, char_pos, key_char,
//          |           |   word_length, text_byte; tlast: last
// m_axis   | out       | tdata: out_byte; tlast: out_last
// cfg      | in        | pair_count, written when i_cfg_we is high
//
// A load word is written into the keyword tables as it is accepted. A text word
// passes through accept, final check and finish plus one scan per decision: each
// decision has a check step, each pair word tried reads its length and then its
// characters one at a time, a match reads the partner length, and each emitted
// byte is pushed directly (pass) or read from the store first (replacement); all
// of it is set by the single read port of the keyword store. A final word flushes
// up to 8 decisions. Synchronous active-low reset clears the lookahead and the
// table count; the table itself holds garbage until loaded. Output stalls hold
// the scan in place, and the last byte of each step waits in a one-word slot.
module bidirectional_word_substitution_unit
    import bws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // pair_index[3:0] side[4] char_pos[7:5]
                                       // key_char[15:8] word_length[19:16]
                                       // text_byte[27:20] zero[31:28]
    input  logic        s_axis_tuser,  // cmd[0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
    output logic        m_axis_tlast
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bws_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

    bws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

endmodule

>>> src/bws_ram.sv
module bws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bws_datapath.sv
module bws_datapath
    import bws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [PCNT_W-1:0] i_cfg_data,
    input  logic [31:0] i_s_tdata,
    input  logic        i_s_tlast,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast
);

    logic [PCNT_W-1:0] r_pair_count;
    logic [7:0]        r_la [LA_DEPTH];
    logic [FILL_W-1:0] r_fill;
    logic              r_pass;
    logic              r_last;
    logic [WCNT_W-1:0] r_w;
    logic [POS_W-1:0]  r_j;
    logic [LEN_W-1:0]  r_lenw;
    logic [LEN_W-1:0]  r_olen;
    logic              r_pend_valid;
    logic [7:0]        r_pend;
    logic              r_out_valid;
    logic [7:0]        r_out;
    logic              r_out_last;

    logic [3:0]        s_pidx;
    logic              s_side;
    logic [POS_W-1:0]  s_pos;
    logic [7:0]        s_kchar;
    logic [LEN_W-1:0]  s_wlen;
    logic [7:0]        s_text;

    logic [WORD_W-1:0] w_word;
    logic [WORD_W-1:0] w_other;
    logic [WORD_W-1:0] len_raddr;
    logic [LEN_W-1:0]  len_rdata;
    logic [7:0]        st_waddr;
    logic [7:0]        st_raddr;
    logic [7:0]        st_rdata;
    logic [PCNT_W-1:0] active;
    logic [FILL_W-1:0] drop_k;
    logic [LEN_W-1:0]  j_next;
    logic              out_free;
    logic [7:0]        push_byte;

    assign s_pidx  = i_s_tdata[3:0];
    assign s_side  = i_s_tdata[4];
    assign s_pos   = i_s_tdata[7:5];
    assign s_kchar = i_s_tdata[15:8];
    assign s_wlen  = i_s_tdata[19:16];
    assign s_text  = i_s_tdata[27:20];

    assign w_word  = r_w[WORD_W-1:0];
    assign w_other = {w_word[WORD_W-1:1], ~w_word[0]};
    assign len_raddr = i_cmd.rd_other ? w_other : w_word;
    assign st_waddr  = {s_pidx, s_side, s_pos};
    assign st_raddr  = i_cmd.rd_emit ? {w_other, r_j} : {w_word, r_j};

    bws_ram #(.WIDTH(LEN_W), .DEPTH(NUM_WORDS)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_accept),
        .i_waddr ({s_pidx, s_side}),
        .i_wdata (s_wlen),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    bws_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_accept),
        .i_waddr (st_waddr),
        .i_wdata (s_kchar),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign active   = (r_pair_count > PCNT_W'(MAX_PAIRS)) ? PCNT_W'(MAX_PAIRS) : r_pair_count;
    assign j_next   = LEN_W'(r_j) + LEN_W'(1);
    assign out_free = !r_out_valid || i_m_tready;
    assign drop_k   = i_cmd.drop_word ? r_lenw : FILL_W'(1);
    assign push_byte = i_cmd.push_ram ? st_rdata : r_la[0];

    assign o_stat.decide_req = (r_fill >= FILL_W'(KEY_LEN)) || (r_last && r_fill != '0);
    assign o_stat.pass       = r_pass;
    assign o_stat.w_done     = r_w >= WCNT_W'({active, 1'b0});
    assign o_stat.len_bad    = (len_rdata == '0) || (len_rdata > LEN_W'(KEY_LEN))
                               || (len_rdata > r_fill);
    assign o_stat.char_eq    = st_rdata == r_la[r_j];
    assign o_stat.j_last     = j_next == r_lenw;
    assign o_stat.olen_zero  = r_olen == '0;
    assign o_stat.e_last     = j_next == r_olen;
    assign o_stat.out_free   = out_free;
    assign o_stat.pend_valid = r_pend_valid;

    // lookahead: append on text words, shift out on drops
    always_ff @(posedge i_clk) begin
        if (i_cmd.text_accept) begin
            r_la[r_fill] <= s_text;
        end else if (i_cmd.drop_one || i_cmd.drop_word) begin
            for (int i = 0; i < LA_DEPTH; i++) begin
                if (i + int'(drop_k) < LA_DEPTH) begin
                    r_la[i] <= r_la[i + int'(drop_k)];
                end
            end
        end
        if (i_cmd.lat_len) begin
            r_lenw <= len_rdata;
        end
        if (i_cmd.lat_olen) begin
            r_olen <= (len_rdata > LEN_W'(KEY_LEN)) ? LEN_W'(KEY_LEN) : len_rdata;
        end
        if (i_cmd.push) begin
            r_pend <= push_byte;
        end
        if (i_cmd.push && r_pend_valid) begin
            r_out      <= r_pend;
            r_out_last <= 1'b0;
        end else if (i_cmd.flush && r_pend_valid) begin
            r_out      <= r_pend;
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count <= '0;
            r_fill       <= '0;
            r_pass       <= 1'b0;
            r_last       <= 1'b0;
            r_w          <= '0;
            r_j          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pair_count <= i_cfg_data;
            end
            if (i_cmd.text_accept) begin
                r_fill <= r_fill + FILL_W'(1);
                r_last <= i_s_tlast;
            end else if (i_cmd.drop_one || i_cmd.drop_word) begin
                r_fill <= r_fill - drop_k;
            end else if (i_cmd.flush && r_last) begin
                r_fill <= '0;
            end
            if (i_cmd.set_pass) begin
                r_pass <= 1'b1;
            end else if (i_cmd.clr_pass || (i_cmd.flush && r_last)) begin
                r_pass <= 1'b0;
            end
            if (i_cmd.w_clr) begin
                r_w <= '0;
            end else if (i_cmd.w_inc) begin
                r_w <= r_w + WCNT_W'(1);
            end
            if (i_cmd.j_clr) begin
                r_j <= '0;
            end else if (i_cmd.j_inc) begin
                r_j <= r_j + POS_W'(1);
            end
            if (i_cmd.push) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if ((i_cmd.push || i_cmd.flush) && r_pend_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;
    assign o_m_tlast  = r_out_last;

endmodule

>>> src/bws_ctrl.sv
module bws_ctrl
    import bws_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  logic     i_s_tuser,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_PASS, S_WORD, S_WLEN, S_CRD, S_CCMP,
        S_OLRD, S_OLEN, S_ERD, S_EPUSH, S_NOMATCH, S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = r_state == S_IDLE;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser == CMD_TEXT) begin
                        o_cmd.text_accept = 1'b1;
                        n_state = S_CHECK;
                    end else begin
                        o_cmd.load_accept = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (!i_stat.decide_req) begin
                    n_state = S_FINISH;
                end else if (i_stat.pass) begin
                    n_state = S_PASS;
                end else begin
                    o_cmd.w_clr = 1'b1;
                    n_state = S_WORD;
                end
            end
            S_PASS: begin
                if (i_stat.out_free) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.drop_one = 1'b1;
                    o_cmd.clr_pass = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_WORD: begin
                // length read of the current word issued here
                o_cmd.j_clr = 1'b1;
                n_state = i_stat.w_done ? S_NOMATCH : S_WLEN;
            end
            S_WLEN: begin
                if (i_stat.len_bad) begin
                    o_cmd.w_inc = 1'b1;
                    n_state = S_WORD;
                end else begin
                    o_cmd.lat_len = 1'b1;
                    n_state = S_CRD;
                end
            end
            S_CRD: begin
                n_state = S_CCMP;
            end
            S_CCMP: begin
                if (!i_stat.char_eq) begin
                    o_cmd.w_inc = 1'b1;
                    n_state = S_WORD;
                end else if (i_stat.j_last) begin
                    o_cmd.rd_other = 1'b1;
                    n_state = S_OLRD;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state = S_CRD;
                end
            end
            S_OLRD: begin
                o_cmd.rd_other = 1'b1;
                o_cmd.lat_olen = 1'b1;
                o_cmd.j_clr    = 1'b1;
                n_state = S_OLEN;
            end
            S_OLEN: begin
                o_cmd.rd_emit = 1'b1;
                if (i_stat.olen_zero) begin
                    o_cmd.drop_word = 1'b1;
                    o_cmd.set_pass  = 1'b1;
                    n_state = S_CHECK;
                end else begin
                    n_state = S_ERD;
                end
            end
            S_ERD: begin
                o_cmd.rd_emit = 1'b1;
                n_state = S_EPUSH;
            end
            S_EPUSH: begin
                o_cmd.rd_emit = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_ram = 1'b1;
                    if (i_stat.e_last) begin
                        o_cmd.drop_word = 1'b1;
                        o_cmd.set_pass  = 1'b1;
                        n_state = S_CHECK;
                    end else begin
                        o_cmd.j_inc = 1'b1;
                        n_state = S_ERD;
                    end
                end
            end
            S_NOMATCH: begin
                if (i_stat.out_free) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.drop_one = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_FINISH: begin
                // pending word leaves with tlast set when the step ends the text
                if (i_stat.out_free || !i_stat.pend_valid) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
